// ===== hw/rtl/mpp_pkg.sv =====
package mpp_pkg;

  // Result action codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_OUT  = 2'd1;
  localparam logic [1:0] ACT_IN   = 2'd2;

  // Cap on result words per input word
  localparam int MAX_RESULTS = 16;

  // Saturation point of a transition counter
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write zero at the clearing pointer, advance it
    logic accept;  // capture the input word, reset walk counters
    logic latch;   // register the current page
    logic check;   // record previous page, issue counter read
    logic incr;    // write back the incremented counter
    logic scan;    // issue and consume row reads
    logic build;   // form the command mask
    logic emit;    // walk the mask into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic run;
    logic need_inc;
    logic scan_done;
    logic emit_end;
  } status_t;

endpackage

// ===== hw/rtl/mpp_ctrl.sv =====
module mpp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mpp_pkg::status_t st,
  output mpp_pkg::cmd_t    cmd,
  output logic            in_stall
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREV  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_INC   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_MASK  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = st.run ? S_PREV : S_EMIT;
      end
      S_PREV: begin
        cmd.latch = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        state_nxt = st.need_inc ? S_INC : S_SCAN;
      end
      S_INC: begin
        cmd.incr  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) state_nxt = S_MASK;
      end
      S_MASK: begin
        cmd.build = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.emit_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/mpp_datapath.sv =====
module mpp_datapath #(
  parameter int NUM_PROCESSES = 16,
  parameter int NUM_PAGES     = 16,
  parameter int PAGE_BYTES    = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mpp_pkg::cmd_t     cmd,
  output mpp_pkg::status_t  st,
  input  logic [3:0]       in_process_id,
  input  logic             in_active,
  input  logic [10:0]      in_program_counter,
  input  logic [15:0]      in_resident_pages,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_action,
  output logic [3:0]       out_page_number,
  output logic             out_last_of_run
);

  localparam int PROC_W    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int PG_W      = $clog2(NUM_PAGES);
  localparam int PGC_W     = $clog2(NUM_PAGES + 1);
  localparam int CNT_DEPTH = NUM_PROCESSES * NUM_PAGES * NUM_PAGES;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);
  localparam int NSLOT     = NUM_PAGES + 3;
  localparam int KW        = $clog2(NSLOT);
  localparam int RES_W     = $clog2(mpp_pkg::MAX_RESULTS);

  function automatic logic [CNT_AW-1:0] cnt_addr(input logic [PROC_W-1:0] p,
                                                 input logic [PG_W-1:0]   f,
                                                 input logic [PG_W-1:0]   t);
    logic [31:0] a;
    a = 32'(p) * 32'(NUM_PAGES * NUM_PAGES) + 32'(f) * 32'(NUM_PAGES) + 32'(t);
    return a[CNT_AW-1:0];
  endfunction

  function automatic logic is_res(input logic [15:0] bits, input logic [PG_W-1:0] p);
    logic [31:0] pe;
    pe = 32'(p);
    return (pe < 32'd16) && bits[pe[3:0]];
  endfunction

  // Input word
  logic [3:0]        pid_r;
  logic [10:0]       pc_r;
  logic [15:0]       res_r;
  logic [6:0]        pid_ext;
  logic [PROC_W-1:0] pidx;

  // Page and history
  logic [NUM_PAGES-2:0] thr_hit;
  logic [PG_W-1:0]      page_calc;
  logic [PG_W-1:0]      page_r;
  logic [PG_W-1:0]      prev_mem [NUM_PROCESSES];
  logic [PG_W-1:0]      prev_q_r;
  logic [NUM_PROCESSES-1:0] prev_ok_r;

  // Counter store
  logic [15:0]       cnt_mem [CNT_DEPTH];
  logic [15:0]       cnt_q_r;
  logic [CNT_AW-1:0] clr_idx_r;
  logic [CNT_AW-1:0] rd_addr;
  logic [CNT_AW-1:0] rmw_addr_r;
  logic [CNT_AW-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              wr_en;
  logic [15:0]       cnt_sat;

  // Row scan
  logic [PGC_W-1:0] scan_i_r;
  logic             rd_pend_r;
  logic [PG_W-1:0]  rd_idx_r;
  logic             consume;
  logic [PG_W-1:0]  best_r;
  logic [15:0]      bv_r;
  logic [PG_W-1:0]  sec_r;
  logic [15:0]      sv_r;
  logic             sec_ok_r;

  // Emission
  logic [NSLOT-1:0] mask_new;
  logic [NSLOT-1:0] mask_r;
  logic [NSLOT-1:0] onehot;
  logic [NSLOT-1:0] rest;
  logic [KW-1:0]    k_r;
  logic [KW-1:0]    q_sel;
  logic [RES_W-1:0] n_r;
  logic             cur;
  logic             last_calc;
  logic             out_free;
  logic             load_none;
  logic             load_cmd;
  logic             step_skip;
  logic [PG_W-1:0]  slot_page;
  logic [1:0]       slot_act;
  logic             out_valid_r;
  logic [1:0]       out_action_r;
  logic [3:0]       out_page_r;
  logic             out_last_r;

  assign pid_ext = 7'(pid_r);
  assign pidx    = pid_ext[PROC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pid_r <= in_process_id;
      pc_r  <= in_program_counter;
      res_r <= in_resident_pages;
    end
  end

  // Page index: count the page boundaries at or below the counter, saturating
  always_comb begin
    thr_hit = '0;
    for (int k = 1; k < NUM_PAGES; k++) begin
      thr_hit[k-1] = (32'(pc_r) >= 32'(k * PAGE_BYTES));
    end
  end
  assign page_calc = PG_W'($countones(thr_hit));

  always_ff @(posedge clk) begin
    if (cmd.latch) page_r <= page_calc;
  end

  always_ff @(posedge clk) begin
    if (cmd.check) prev_mem[pidx] <= page_r;
    prev_q_r <= prev_mem[pidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ok_r <= '0;
    end else if (cmd.check) begin
      prev_ok_r[pidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear) begin
      clr_idx_r <= clr_idx_r + CNT_AW'(1);
    end
  end

  assign rd_addr = cmd.check ? cnt_addr(pidx, prev_q_r, page_r)
                             : cnt_addr(pidx, page_r, scan_i_r[PG_W-1:0]);
  assign cnt_sat = (cnt_q_r == mpp_pkg::COUNT_MAX) ? cnt_q_r : cnt_q_r + 16'd1;
  assign wr_en   = cmd.clear | cmd.incr;
  assign wr_addr = cmd.clear ? clr_idx_r : rmw_addr_r;
  assign wr_data = cmd.clear ? 16'd0 : cnt_sat;

  always_ff @(posedge clk) begin
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
    cnt_q_r <= cnt_mem[rd_addr];
    if (cmd.check) rmw_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_i_r  <= '0;
      rd_pend_r <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_i_r < PGC_W'(NUM_PAGES)) begin
        scan_i_r  <= scan_i_r + PGC_W'(1);
        rd_pend_r <= 1'b1;
        rd_idx_r  <= scan_i_r[PG_W-1:0];
      end else begin
        rd_pend_r <= 1'b0;
      end
    end
  end

  assign consume = cmd.scan && rd_pend_r;

  // Running top two, ties to the lower index
  always_ff @(posedge clk) begin
    if (consume) begin
      if (rd_idx_r == '0) begin
        best_r   <= '0;
        bv_r     <= cnt_q_r;
        sec_ok_r <= 1'b0;
      end else if (cnt_q_r > bv_r) begin
        sec_r    <= best_r;
        sv_r     <= bv_r;
        sec_ok_r <= 1'b1;
        best_r   <= rd_idx_r;
        bv_r     <= cnt_q_r;
      end else if (!sec_ok_r || cnt_q_r > sv_r) begin
        sec_r    <= rd_idx_r;
        sv_r     <= cnt_q_r;
        sec_ok_r <= 1'b1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PAGES; k++) begin
      mask_new[k] = is_res(res_r, PG_W'(k)) && (PG_W'(k) != page_r) &&
                    (PG_W'(k) != best_r) && (PG_W'(k) != sec_r);
    end
    mask_new[NUM_PAGES]   = !is_res(res_r, page_r);
    mask_new[NUM_PAGES+1] = (best_r != page_r) && !is_res(res_r, best_r);
    mask_new[NUM_PAGES+2] = (sec_r != page_r) && (sec_r != best_r) &&
                            !is_res(res_r, sec_r);
  end

  assign onehot    = NSLOT'(1) << k_r;
  assign rest      = mask_r & ~onehot;
  assign cur       = |(mask_r & onehot);
  assign last_calc = (rest == '0) || (n_r == RES_W'(mpp_pkg::MAX_RESULTS - 1));
  assign q_sel     = k_r - KW'(NUM_PAGES);

  always_comb begin
    if (32'(k_r) < NUM_PAGES) begin
      slot_page = PG_W'(k_r);
      slot_act  = mpp_pkg::ACT_OUT;
    end else begin
      slot_act = mpp_pkg::ACT_IN;
      case (q_sel)
        KW'(0):  slot_page = page_r;
        KW'(1):  slot_page = best_r;
        default: slot_page = sec_r;
      endcase
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign load_none = cmd.emit && (mask_r == '0) && out_free;
  assign load_cmd  = cmd.emit && cur && out_free;
  assign step_skip = cmd.emit && (mask_r != '0) && !cur;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mask_r <= '0;
      k_r    <= '0;
      n_r    <= '0;
    end else if (cmd.build) begin
      mask_r <= mask_new;
    end else if (load_cmd) begin
      mask_r <= rest;
      k_r    <= k_r + KW'(1);
      n_r    <= n_r + RES_W'(1);
    end else if (step_skip) begin
      k_r <= k_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_none || load_cmd) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_none) begin
      out_action_r <= mpp_pkg::ACT_NONE;
      out_page_r   <= 4'd0;
      out_last_r   <= 1'b1;
    end else if (load_cmd) begin
      out_action_r <= slot_act;
      out_page_r   <= 4'(slot_page);
      out_last_r   <= last_calc;
    end
  end

  assign st.clear_done = cmd.clear && (clr_idx_r == CNT_AW'(CNT_DEPTH - 1));
  assign st.run        = in_active && (32'(in_process_id) < NUM_PROCESSES);
  assign st.need_inc   = prev_ok_r[pidx] && (prev_q_r != page_r);
  assign st.scan_done  = consume && (rd_idx_r == PG_W'(NUM_PAGES - 1));
  assign st.emit_end   = load_none || (load_cmd && last_calc);

  assign out_valid       = out_valid_r;
  assign out_action      = out_action_r;
  assign out_page_number = out_page_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== hw/rtl/markov_page_prefetch_predictor.sv =====
// Per-process page predictor. Each input word is one scheduler tick: process
// id, active flag, program counter and resident-page bitmap. The block keeps
// a saturating transition count per process and page pair and answers with
// a run of command words: page-out for resident pages that are neither the
// current page nor its two likeliest successors, then page-in for whichever
// of those three are absent. The final word of a run carries last_of_run;
// an inactive tick or a tick with nothing to do gives one no-action word.
// Both channels move a word when valid is high and stall is low.
// Input words are taken one at a time: an active tick goes through history
// read, optional counter update and one counter-store read per page of the
// row before emission, then walks the command slots, NUM_PAGES + 3 at most,
// a stalled output holding the walk. An inactive tick goes straight from
// acceptance to emission. The counter store has one read port, so the row
// is read one page at a time.
// Reset: a clearing pass zeroes all NUM_PROCESSES * NUM_PAGES * NUM_PAGES
// counter-store entries (4096 by default), one entry per cycle, with
// in_stall high; the history valid bits clear at once.
// A stalled receiver holds the output register; the next input word may be
// accepted while the last word of a run still waits there.
module markov_page_prefetch_predictor #(
  parameter int NUM_PROCESSES = 16,
  parameter int NUM_PAGES     = 16,
  parameter int PAGE_BYTES    = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_process_id,
  input  logic        in_active,
  input  logic [10:0] in_program_counter,
  input  logic [15:0] in_resident_pages,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [3:0]  out_page_number,
  output logic        out_last_of_run
);

  mpp_pkg::cmd_t    cmd;
  mpp_pkg::status_t st;

  // Sequencer: clearing pass, history, counter update, row scan, emission
  mpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Stores, top-two pick, command mask and output register
  mpp_datapath #(
    .NUM_PROCESSES (NUM_PROCESSES),
    .NUM_PAGES     (NUM_PAGES),
    .PAGE_BYTES    (PAGE_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_process_id      (in_process_id),
    .in_active          (in_active),
    .in_program_counter (in_program_counter),
    .in_resident_pages  (in_resident_pages),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_page_number    (out_page_number),
    .out_last_of_run    (out_last_of_run)
  );

  // A no-action word always closes its run
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == mpp_pkg::ACT_NONE) |-> out_last_of_run)
    else $error("no-action word without last_of_run");

  // Only defined action codes leave the block
  a_act_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_action == mpp_pkg::ACT_NONE) ||
                  (out_action == mpp_pkg::ACT_OUT) ||
                  (out_action == mpp_pkg::ACT_IN))
    else $error("undefined action code");

  // Clearing pass holds off input straight after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input taken during clearing pass");

  // Output register empty after reset
  a_out_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output word present after reset");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  // Block geometry, as built by default
  localparam int NUM_PROCESSES = 16;
  localparam int NUM_PAGES     = 16;
  localparam int PAGE_BYTES    = 128;

  localparam int RANDOM_TICKS = 82;       // active ticks in the random part
  localparam int DRAIN_CYCLES = 50;       // linger after the last owed word to catch any stray word
  localparam int CYCLE_LIMIT  = 400000;   // clearing pass plus worst-case stalls, well padded
  localparam int HOLD_AT_WORD = 150;      // result word that triggers the long hold-off
  localparam int HOLD_CYCLES  = 600;

  // One result word as it leaves the block
  typedef struct packed {
    logic [1:0] action;
    logic [3:0] page;
    logic       last;
  } cmd_word_t;

  // One scheduler tick; up to two result words may be typed in directly
  typedef struct packed {
    logic [3:0]  pid;
    logic        active;
    logic [10:0] pc;
    logic [15:0] resident;
    logic [1:0]  n_typed;   // zero: the words come from the page forecast
    cmd_word_t   typed0;
    cmd_word_t   typed1;
  } tick_row_t;

  localparam cmd_word_t NO_WORD   = '0;
  localparam cmd_word_t IDLE_LAST = '{mpp_pkg::ACT_NONE, 4'd0, 1'b1};
  localparam cmd_word_t IN_0      = '{mpp_pkg::ACT_IN, 4'd0, 1'b0};
  localparam cmd_word_t IN_1_LAST = '{mpp_pkg::ACT_IN, 4'd1, 1'b1};

  localparam int DIR_ROWS = 17;

  // Directed ticks. Process 1 walks pages 2,3,2,4,2 so that page 2's row holds a tie
  // between 3 and 4; its last tick leaves only those three absent, which fills all
  // sixteen result slots.
  tick_row_t directed_ticks [DIR_ROWS] = '{
    '{4'd0,  1'b0, 11'h000, 16'h0000, 2'd1, IDLE_LAST, NO_WORD},   // inactive, all low
    '{4'd15, 1'b0, 11'h7FF, 16'hFFFF, 2'd1, IDLE_LAST, NO_WORD},   // inactive, all high
    '{4'd0,  1'b1, 11'h000, 16'h0000, 2'd2, IN_0, IN_1_LAST},      // first tick, empty row
    '{4'd0,  1'b1, 11'h07F, 16'h0003, 2'd1, IDLE_LAST, NO_WORD},   // same page, nothing to do
    '{4'd0,  1'b1, 11'h080, 16'hFFFF, 2'd0, NO_WORD, NO_WORD},     // 0 -> 1
    '{4'd0,  1'b1, 11'h000, 16'hFFFF, 2'd0, NO_WORD, NO_WORD},     // 1 -> 0
    '{4'd0,  1'b1, 11'h7FF, 16'h0000, 2'd0, NO_WORD, NO_WORD},     // 0 -> 15, top page
    '{4'd15, 1'b1, 11'h7FF, 16'hFFFF, 2'd0, NO_WORD, NO_WORD},     // first tick, top process
    '{4'd1,  1'b1, 11'h100, 16'h0007, 2'd1, IDLE_LAST, NO_WORD},   // first tick, all picks in
    '{4'd1,  1'b1, 11'h180, 16'h0000, 2'd0, NO_WORD, NO_WORD},     // 2 -> 3
    '{4'd1,  1'b0, 11'h280, 16'h5555, 2'd1, IDLE_LAST, NO_WORD},   // inactive, history kept
    '{4'd1,  1'b1, 11'h100, 16'hAAAA, 2'd0, NO_WORD, NO_WORD},     // 3 -> 2
    '{4'd1,  1'b1, 11'h200, 16'h0F0F, 2'd0, NO_WORD, NO_WORD},     // 2 -> 4
    '{4'd1,  1'b1, 11'h17F, 16'hFFE3, 2'd0, NO_WORD, NO_WORD},     // 4 -> 2, sixteen words
    '{4'd15, 1'b1, 11'h000, 16'h8000, 2'd0, NO_WORD, NO_WORD},     // 15 -> 0
    '{4'd15, 1'b1, 11'h7FF, 16'h0000, 2'd0, NO_WORD, NO_WORD},     // 0 -> 15
    '{4'd15, 1'b1, 11'h000, 16'h7FFF, 2'd0, NO_WORD, NO_WORD}      // 15 -> 0 again
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_process_id = '0;
  logic        in_active = 1'b0;
  logic [10:0] in_program_counter = '0;
  logic [15:0] in_resident_pages = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_action;
  logic [3:0]  out_page_number;
  logic        out_last_of_run;

  markov_page_prefetch_predictor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_process_id      (in_process_id),
    .in_active          (in_active),
    .in_program_counter (in_program_counter),
    .in_resident_pages  (in_resident_pages),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_page_number    (out_page_number),
    .out_last_of_run    (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the block's state: transition counts and each process's last page
  logic [15:0] hop_count [NUM_PROCESSES][NUM_PAGES][NUM_PAGES];
  logic [3:0]  prev_page [NUM_PROCESSES];
  logic        prev_known [NUM_PROCESSES];

  cmd_word_t fresh_run [$];   // words forecast for the tick just accepted
  cmd_word_t due_cmds [$];    // words still owed by the block, oldest first
  int        mismatches = 0;

  initial begin
    foreach (hop_count[p, f, t]) hop_count[p][f][t] = '0;
    foreach (prev_known[p]) prev_known[p] = 1'b0;
    foreach (prev_page[p]) prev_page[p] = '0;
  end

  // Count the transition, pick the two likeliest successors and lay out the run of
  // page-out words followed by page-in words.
  function automatic void forecast_commands(input logic [3:0] pid, input logic active,
                                            input logic [10:0] pc, input logic [15:0] resident);
    int          page_i;
    logic [3:0]  cur;
    logic [3:0]  best;
    logic [3:0]  second;
    logic [3:0]  picks [3];
    logic        dup;
    fresh_run.delete();
    if (!active) begin
      fresh_run.push_back(IDLE_LAST);
      return;
    end
    page_i = int'(pc) / PAGE_BYTES;
    if (page_i >= NUM_PAGES) page_i = NUM_PAGES - 1;
    cur = 4'(page_i);

    // Count only a real move; saturate at the top
    if (prev_known[pid] && prev_page[pid] != cur &&
        hop_count[pid][prev_page[pid]][cur] != mpp_pkg::COUNT_MAX)
      hop_count[pid][prev_page[pid]][cur] = hop_count[pid][prev_page[pid]][cur] + 16'd1;
    prev_page[pid]  = cur;
    prev_known[pid] = 1'b1;

    // Strictly greater wins, so ties fall to the lowest page
    best = 4'd0;
    for (int j = 1; j < NUM_PAGES; j++)
      if (hop_count[pid][cur][j] > hop_count[pid][cur][best]) best = 4'(j);
    second = (best == 4'd0) ? 4'd1 : 4'd0;
    for (int j = 0; j < NUM_PAGES; j++)
      if (4'(j) != best && hop_count[pid][cur][j] > hop_count[pid][cur][second])
        second = 4'(j);

    for (int j = 0; j < NUM_PAGES; j++)
      if (fresh_run.size() < mpp_pkg::MAX_RESULTS && 4'(j) != cur && 4'(j) != best &&
          4'(j) != second && j < 16 && resident[j])
        fresh_run.push_back('{mpp_pkg::ACT_OUT, 4'(j), 1'b0});

    picks[0] = cur;
    picks[1] = best;
    picks[2] = second;
    for (int q = 0; q < 3; q++) begin
      dup = 1'b0;
      for (int r = 0; r < q; r++)
        if (picks[r] == picks[q]) dup = 1'b1;
      if (fresh_run.size() < mpp_pkg::MAX_RESULTS && !dup && !resident[picks[q]])
        fresh_run.push_back('{mpp_pkg::ACT_IN, picks[q], 1'b0});
    end

    if (fresh_run.size() == 0) fresh_run.push_back(IDLE_LAST);
    fresh_run[fresh_run.size() - 1].last = 1'b1;
  endfunction

  // Quiet stretches with no gaps, random gaps elsewhere
  function automatic int sender_gap(input int idx);
    return ((idx % 30) < 8) ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Offer one tick, hold it until the block takes it, then book its result words.
  // Valid stays high straight into the next tick when no gap is drawn.
  task automatic offer_tick(input tick_row_t row, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_process_id      <= row.pid;
    in_active          <= row.active;
    in_program_counter <= row.pc;
    in_resident_pages  <= row.resident;
    do @(posedge clk); while (in_stall !== 1'b0);
    forecast_commands(row.pid, row.active, row.pc, row.resident);
    if (row.n_typed == 2'd0) begin
      foreach (fresh_run[k]) due_cmds.push_back(fresh_run[k]);
    end else begin
      due_cmds.push_back(row.typed0);
      if (row.n_typed == 2'd2) due_cmds.push_back(row.typed1);
    end
  endtask

  // Sender: reset, directed table, then random ticks; finally drain and judge
  initial begin
    tick_row_t row;
    int        active_sent;
    int        idx;
    int        page;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ticks[i]) offer_tick(directed_ticks[i], sender_gap(i));

    // Mostly active ticks on a few processes and pages so that rows fill up;
    // the rest roams the whole field range or is inactive.
    active_sent = 0;
    idx = DIR_ROWS;
    while (active_sent < RANDOM_TICKS) begin
      row = '0;
      row.pid    = 4'($urandom);
      row.active = ($urandom_range(0, 99) >= 12);
      if (row.active && $urandom_range(0, 9) < 7) row.pid = 4'($urandom_range(0, 3));
      page = ($urandom_range(0, 99) < 65) ? int'($urandom_range(0, 3))
                                          : int'($urandom_range(0, 15));
      row.pc = {4'(page), 7'($urandom)};
      case ($urandom_range(0, 9))
        0, 1: begin
          row.resident = 16'hFFFF;
        end
        2: begin
          row.resident = 16'h0000;
        end
        default: begin
          row.resident = 16'($urandom);
        end
      endcase
      offer_tick(row, sender_gap(idx));
      if (row.active) active_sent++;
      idx++;
    end
    in_valid <= 1'b0;

    // Drain, then linger to catch any stray word
    while (due_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stall before each word, quiet stretches, and one long hold-off
  // that backs the block up into its input while the sender keeps offering.
  initial begin
    int word_idx;
    int wait_cycles;
    word_idx = 0;
    forever begin
      if (word_idx == HOLD_AT_WORD) begin
        wait_cycles = HOLD_CYCLES;
      end else if ((word_idx % 40) < 10) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = int'($urandom_range(0, 12));
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      word_idx++;
    end
  end

  // Compare each accepted word with the oldest one owed
  always @(posedge clk) begin
    cmd_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_cmds.size() == 0) begin
        $display("%0t: unexpected word: expected none, got action %0d page %0d last %0d",
                 $time, out_action, out_page_number, out_last_of_run);
        mismatches++;
      end else begin
        want = due_cmds.pop_front();
        if (out_action !== want.action) begin
          $display("%0t: action: expected %0d, got %0d", $time, want.action, out_action);
          mismatches++;
        end
        if (out_page_number !== want.page) begin
          $display("%0t: page_number: expected %0d, got %0d",
                   $time, want.page, out_page_number);
          mismatches++;
        end
        if (out_last_of_run !== want.last) begin
          $display("%0t: last_of_run: expected %0d, got %0d",
                   $time, want.last, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stop a hung run
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d words outstanding",
             $time, cycles, due_cmds.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
